// ----- rtl/core/csp_pkg.sv -----
package csp_pkg;

  localparam int unsigned LOAD_FACTOR = 8;

  localparam int unsigned TopicsW   = 20;
  localparam int unsigned CapW      = 40;
  localparam int unsigned CountW    = 31;
  localparam int unsigned UsedW     = 48;
  localparam int unsigned SliceW    = 24;
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 40;

  localparam logic [CfgIndexW-1:0] RegNumTopics    = 2'd0;
  localparam logic [CfgIndexW-1:0] RegModelCapacity = 2'd1;
  localparam logic [CfgIndexW-1:0] RegAliasCapacity = 2'd2;
  localparam logic [CfgIndexW-1:0] RegDeltaCapacity = 2'd3;

  localparam logic [TopicsW-1:0] NumTopicsReset = 20'd1024;

  localparam logic [UsedW-1:0] ModelThrMul  = UsedW'(2 * LOAD_FACTOR);
  localparam logic [UsedW-1:0] DeltaThrMul  = UsedW'(4 * LOAD_FACTOR);
  localparam logic [UsedW-1:0] ModelSparseMul = UsedW'(4 * LOAD_FACTOR);
  localparam logic [UsedW-1:0] DeltaSparseMul = UsedW'(8 * LOAD_FACTOR);
  localparam logic [UsedW-1:0] AliasSparseMul = UsedW'(12);

  function automatic logic [UsedW-1:0] sat_add(input logic [UsedW-1:0] a,
                                               input logic [UsedW-1:0] b);
    logic [UsedW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[UsedW] ? {UsedW{1'b1}} : s[UsedW-1:0];
  endfunction

endpackage

// ----- rtl/core/capacity_slice_partitioner.sv -----
// Channel  Role    Handshake                  Payload
// -------  ------  -------------------------  ------------------------------------------------
// in       sink    in_valid_i / in_ready_o    global_count_i, local_count_i, block_start_i
// out      source  out_valid_o / out_ready_i  slice_break_o, slice_number_o, model/alias/delta_used_o
// cfg      sink    cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One word per cycle sustained while the output is not stalled.
// The word is held in an input register, then sizes, offsets and the slice
// decision are formed and committed to the offset registers as the result loads.
// Reset clears offsets, slice count and capacities and sets the topic count to 1024.
// A stalled result holds the input register full; ready drops only then.
module capacity_slice_partitioner
  import csp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [CountW-1:0]    global_count_i,
  input  logic [CountW-1:0]    local_count_i,
  input  logic                 block_start_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 slice_break_o,
  output logic [SliceW-1:0]    slice_number_o,
  output logic [UsedW-1:0]     model_used_o,
  output logic [UsedW-1:0]     alias_used_o,
  output logic [UsedW-1:0]     delta_used_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  logic [TopicsW-1:0] topics_q;
  logic [CapW-1:0]    model_cap_q, alias_cap_q, delta_cap_q;

  logic               s1_valid_q;
  logic [CountW-1:0]  gc_q, lc_q;
  logic               start_q;

  logic               out_valid_q, brk_q;
  logic [UsedW-1:0]   model_acc_q, alias_acc_q, delta_acc_q;
  logic [UsedW-1:0]   model_acc_d, alias_acc_d, delta_acc_d;
  logic [SliceW-1:0]  slice_cnt_q, slice_cnt_d;

  logic               advance;
  logic [UsedW-1:0]   gc_w, lc_w, t_w;
  logic [UsedW-1:0]   msz, asz, dsz;
  logic [UsedW-1:0]   m_base, a_base, d_base;
  logic [UsedW-1:0]   mo, ao, dof;
  logic [SliceW-1:0]  cnt_base;
  logic               brk_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      topics_q    <= NumTopicsReset;
      model_cap_q <= '0;
      alias_cap_q <= '0;
      delta_cap_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegNumTopics:     topics_q    <= cfg_data_i[TopicsW-1:0];
        RegModelCapacity: model_cap_q <= cfg_data_i[CapW-1:0];
        RegAliasCapacity: alias_cap_q <= cfg_data_i[CapW-1:0];
        RegDeltaCapacity: delta_cap_q <= cfg_data_i[CapW-1:0];
        default: ;
      endcase
    end
  end

  assign advance    = s1_valid_q && (out_ready_i || !out_valid_q);
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      gc_q    <= global_count_i;
      lc_q    <= local_count_i;
      start_q <= block_start_i;
    end
  end

  // gc > floor(T/D) holds exactly when gc*D > T
  always_comb begin
    gc_w = UsedW'(gc_q);
    lc_w = UsedW'(lc_q);
    t_w  = UsedW'(topics_q);

    msz = (gc_w * ModelThrMul > t_w) ? (t_w << 2) : gc_w * ModelSparseMul;
    asz = ((gc_w << 1) + gc_w > (t_w << 1)) ? (t_w << 3) : gc_w * AliasSparseMul;
    dsz = (lc_w * DeltaThrMul > t_w) ? (t_w << 2) : lc_w * DeltaSparseMul;

    m_base   = start_q ? '0 : model_acc_q;
    a_base   = start_q ? '0 : alias_acc_q;
    d_base   = start_q ? '0 : delta_acc_q;
    cnt_base = start_q ? '0 : slice_cnt_q;

    mo  = sat_add(m_base, msz);
    ao  = sat_add(a_base, asz);
    dof = sat_add(d_base, dsz);

    brk_d = (mo > UsedW'(model_cap_q)) || (ao > UsedW'(alias_cap_q)) ||
            (dof > UsedW'(delta_cap_q));

    if (brk_d) begin
      model_acc_d = msz;
      alias_acc_d = asz;
      delta_acc_d = dsz;
      slice_cnt_d = (cnt_base == {SliceW{1'b1}}) ? cnt_base : cnt_base + 1'b1;
    end else begin
      model_acc_d = mo;
      alias_acc_d = ao;
      delta_acc_d = dof;
      slice_cnt_d = cnt_base;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      model_acc_q <= '0;
      alias_acc_q <= '0;
      delta_acc_q <= '0;
      slice_cnt_q <= '0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        model_acc_q <= model_acc_d;
        alias_acc_q <= alias_acc_d;
        delta_acc_q <= delta_acc_d;
        slice_cnt_q <= slice_cnt_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      brk_q <= brk_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign slice_break_o  = brk_q;
  assign slice_number_o = slice_cnt_q;
  assign model_used_o   = model_acc_q;
  assign alias_used_o   = alias_acc_q;
  assign delta_used_o   = delta_acc_q;

endmodule
